@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check sampled on clk, off while reset is asserted
`define APT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("apt check failed");

// concurrent check that also runs through reset
`define APT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("apt check failed");

`else

`define APT_ASSERT(lbl, clk, rst_n, prop)
`define APT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/apt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

	localparam int NUM_LANES = 3;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] coef_t;
	typedef logic signed [47:0] prod_t;
	typedef logic signed [35:0] rnd_t;
	typedef logic signed [37:0] sum_t;
	typedef logic [47:0]        row_t;

	typedef enum logic [2:0] {
		REG_ROW0    = 3'd0,
		REG_ROW1    = 3'd1,
		REG_ROW2    = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} cfg_idx_t;

	// identity transform, coefficients in q4.12
	localparam row_t ROW0_RESET = 48'h1000_0000_0000;
	localparam row_t ROW1_RESET = 48'h0000_1000_0000;
	localparam row_t ROW2_RESET = 48'h0000_0000_1000;

	localparam prod_t ROUND_HALF = 48'sd2048;
	localparam int    FRAC_DROP  = 12;

	localparam sum_t SAT_HI = 38'sd2147483647;
	localparam sum_t SAT_LO = -38'sd2147483648;

	localparam coord_t COORD_MAX = 32'sh7fff_ffff;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	// pipeline step control handed to the merge stage
	typedef struct packed {
		logic load;
		logic valid;
	} stage_ctrl_t;

endpackage

`default_nettype wire

@@ src/apt_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// one output coordinate: three products, rounding, sum with translation
module apt_lane import apt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   advance,
	input  wire coord_t point [NUM_LANES],
	input  wire row_t   row,
	input  wire coord_t shift,
	output sum_t        sum_s3
);

	prod_t  prod_s1 [NUM_LANES];
	coord_t shift_s1;
	rnd_t   rnd_s2  [NUM_LANES];
	coord_t shift_s2;
	coef_t  coef    [NUM_LANES];
	rnd_t   rnd_d   [NUM_LANES];

	// coefficient k sits at bits (2-k)*16 upward
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			coef[k] = coef_t'(row[(NUM_LANES - 1 - k) * 16 +: 16]);
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			rnd_d[k] = rnd_t'((prod_s1[k] + ROUND_HALF) >>> FRAC_DROP);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				prod_s1[k] <= prod_t'(point[k]) * prod_t'(coef[k]);
				rnd_s2[k]  <= rnd_d[k];
			end
			shift_s1 <= shift;
			shift_s2 <= shift_s1;
			sum_s3   <= sum_t'(rnd_s2[0]) + sum_t'(rnd_s2[1]) + sum_t'(rnd_s2[2])
				+ sum_t'(shift_s2);
		end
	end

endmodule

`default_nettype wire

@@ src/apt_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// saturates the lane sums, joins their flags and holds the result
module apt_merge import apt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire stage_ctrl_t ctrl,
	input  wire sum_t        sum_s3 [NUM_LANES],
	output logic             out_valid,
	output coord_t           moved_x,
	output coord_t           moved_y,
	output coord_t           moved_z,
	output logic             overflow
);

	coord_t sat_d [NUM_LANES];
	logic   [NUM_LANES-1:0] ovf_d;
	logic   valid_q;
	coord_t moved_q [NUM_LANES];
	logic   ovf_q;

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			if (sum_s3[k] > SAT_HI) begin
				sat_d[k] = COORD_MAX;
				ovf_d[k] = 1'b1;
			end else if (sum_s3[k] < SAT_LO) begin
				sat_d[k] = COORD_MIN;
				ovf_d[k] = 1'b1;
			end else begin
				sat_d[k] = coord_t'(sum_s3[k]);
				ovf_d[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			moved_q <= sat_d;
			ovf_q   <= |ovf_d;
		end
	end

	assign out_valid = valid_q;
	assign moved_x   = moved_q[0];
	assign moved_y   = moved_q[1];
	assign moved_z   = moved_q[2];
	assign overflow  = ovf_q;

	// a flagged result carries at least one clamped coordinate
	`APT_ASSERT(a_ovf_clamped, clk, arst_n,
		(valid_q && ovf_q) |-> (moved_q[0] == COORD_MAX || moved_q[0] == COORD_MIN ||
		moved_q[1] == COORD_MAX || moved_q[1] == COORD_MIN ||
		moved_q[2] == COORD_MAX || moved_q[2] == COORD_MIN))

endmodule

`default_nettype wire

@@ src/affine_point_transform_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// path: product, rounding and sum stages in each lane feed the output register
// throughput: one point per cycle while out_stall holds no result, set by
//   three lanes of three 32x16 multipliers each, one per output coordinate
// reset: arst_n clears all valid flags and loads the identity matrix with zero
//   translation; no clearing pass, items are taken right after reset

`include "assert_macros.svh"

module affine_point_transform_top import apt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input point channel
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire coord_t       point_x,
	input  wire coord_t       point_y,
	input  wire coord_t       point_z,
	// result channel
	output logic              out_valid,
	input  wire logic         out_stall,
	output coord_t            moved_x,
	output coord_t            moved_y,
	output coord_t            moved_z,
	output logic              overflow,
	// configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);

	// matrix rows and translations
	row_t   row_q   [NUM_LANES];
	coord_t shift_q [NUM_LANES];

	// pipeline occupancy
	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   advance;

	coord_t      point [NUM_LANES];
	sum_t        sum_s3 [NUM_LANES];
	stage_ctrl_t merge_ctrl;

	// the whole pipe steps together; it only holds while a finished result
	// waits on the output register
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	// writes are taken every cycle, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ROW0_RESET;
			row_q[1]   <= ROW1_RESET;
			row_q[2]   <= ROW2_RESET;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_ROW0: begin
					row_q[0] <= cfg_data;
				end
				REG_ROW1: begin
					row_q[1] <= cfg_data;
				end
				REG_ROW2: begin
					row_q[2] <= cfg_data;
				end
				REG_SHIFT_X: begin
					shift_q[0] <= coord_t'(cfg_data[31:0]);
				end
				REG_SHIFT_Y: begin
					shift_q[1] <= coord_t'(cfg_data[31:0]);
				end
				REG_SHIFT_Z: begin
					shift_q[2] <= coord_t'(cfg_data[31:0]);
				end
				default: begin
					// index past the register list, transaction ignored
				end
			endcase
		end
	end

	// valid flags follow the payload down the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign point[0] = point_x;
	assign point[1] = point_y;
	assign point[2] = point_z;

	// one lane per output coordinate, each sees the full point
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		apt_lane u_lane (
			.clk     (clk),
			.advance (advance),
			.point   (point),
			.row     (row_q[g]),
			.shift   (shift_q[g]),
			.sum_s3  (sum_s3[g])
		);
	end

	assign merge_ctrl.load  = advance;
	assign merge_ctrl.valid = valid_s3;

	// saturation, overflow merge and the output register
	apt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (merge_ctrl),
		.sum_s3    (sum_s3),
		.out_valid (out_valid),
		.moved_x   (moved_x),
		.moved_y   (moved_y),
		.moved_z   (moved_z),
		.overflow  (overflow)
	);

	// an item leaving the last lane stage lands on the output register
	`APT_ASSERT(a_s3_to_out, clk, arst_n, (valid_s3 && advance) |=> out_valid)

	// a held pipe keeps the occupancy of its first stage
	`APT_ASSERT(a_hold_s1, clk, arst_n, in_stall |=> (valid_s1 == $past(valid_s1)))

	// a stall only comes from a full output register
	`APT_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall))

	// the edge after one seen in reset finds nothing in flight
	`APT_ASSERT_ALWAYS(a_reset_empty, clk,
		!arst_n |=> (!valid_s1 && !valid_s2 && !valid_s3 && !out_valid))

endmodule

`default_nettype wire
